// ----- rtl/core/rbag_pkg.sv -----
`timescale 1ns / 1ps

package rbag_pkg;

  // coordinate fields
  localparam int COORD_BITS = 16;
  localparam int FB         = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam logic [15:0] FMASK = 16'((32'd1 << FB) - 32'd1);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // mode flag bit positions
  localparam int MODE_COPY = 0;
  localparam int MODE_MIRX = 1;
  localparam int MODE_MIRY = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_DST_SIZE = 3'd1;
  localparam logic [2:0] CFG_SRC_SIZE = 3'd2;
  localparam logic [2:0] CFG_DST_ORG  = 3'd3;
  localparam logic [2:0] CFG_SRC_ORG  = 3'd4;
  localparam logic [2:0] CFG_RECT     = 3'd5;
  localparam logic [2:0] CFG_FILL     = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NEG = 2'd1;
  localparam logic [1:0] ST_OOB = 2'd2;

  typedef logic [15:0] coord_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] dst_size;
    logic [31:0] src_size;
    logic [31:0] dst_origin;
    logic [31:0] src_origin;
    logic [31:0] rect_size;
    logic [31:0] fill_colour;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [31:0] pixel;
    logic [1:0]  status;
    logic        we;
    logic        last;
    logic        copy;
    coord_t      cx;
    coord_t      cy;
    coord_t      col;
    coord_t      row;
  } entry_t;

  // used low bits of a 16-bit half of a register
  function automatic coord_t fld(input logic [31:0] r, input logic hi);
    coord_t v;
    v = hi ? r[31:16] : r[15:0];
    return v & FMASK;
  endfunction

  function automatic logic is_neg(input coord_t v);
    return v[FB-1];
  endfunction

endpackage

// ----- rtl/core/rbag_queue.sv -----
`timescale 1ns / 1ps

module rbag_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rbag_pkg::entry_t push_data,
  input  logic             pop,
  output rbag_pkg::entry_t head,
  output logic             not_empty,
  output logic             full
);
  import rbag_pkg::*;

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head      = mem_r[rptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == QCNT_W'(QDEPTH));

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
      if (pop)  rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

// ----- rtl/core/rbag_front.sv -----
`timescale 1ns / 1ps

module rbag_front (
  input  logic             clk,
  input  logic             rst_n,
  input  rbag_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  logic [31:0]      in_source_pixel,
  input  logic             q_full,
  output logic             push,
  output rbag_pkg::entry_t push_data
);
  import rbag_pkg::*;

  logic   job_active_r, job_active_nxt;
  coord_t col_r, col_nxt, row_r, row_nxt;

  logic   copy, neg, oob, start, col_end, row_end;
  coord_t dw, dh, sw, sh, dx, dy, sx, sy, rw, rh, col, row;

  assign push = in_valid && !q_full;

  // geometry fields
  always_comb begin
    copy = cfg.mode[MODE_COPY];
    dw = fld(cfg.dst_size, 1'b0);   dh = fld(cfg.dst_size, 1'b1);
    sw = fld(cfg.src_size, 1'b0);   sh = fld(cfg.src_size, 1'b1);
    dx = fld(cfg.dst_origin, 1'b0); dy = fld(cfg.dst_origin, 1'b1);
    sx = fld(cfg.src_origin, 1'b0); sy = fld(cfg.src_origin, 1'b1);
    rw = fld(cfg.rect_size, 1'b0);  rh = fld(cfg.rect_size, 1'b1);
  end

  // first-item checks
  always_comb begin
    neg = is_neg(dx) || is_neg(dy) || (copy && (is_neg(sx) || is_neg(sy)));
    oob = ({1'b0, dx} + {1'b0, rw} > {1'b0, dw}) ||
          ({1'b0, dy} + {1'b0, rh} > {1'b0, dh}) ||
          (copy && (({1'b0, sx} + {1'b0, rw} > {1'b0, sw}) ||
                    ({1'b0, sy} + {1'b0, rh} > {1'b0, sh})));
  end

  // classify item and step the raster counters
  always_comb begin
    start   = !job_active_r;
    col     = start ? '0 : col_r;
    row     = start ? '0 : row_r;
    col_end = ({1'b0, col} + 17'd1) >= {1'b0, rw};
    row_end = ({1'b0, row} + 17'd1) >= {1'b0, rh};

    push_data        = '0;
    job_active_nxt   = job_active_r;
    col_nxt          = col_r;
    row_nxt          = row_r;

    priority if (start && neg) begin
      push_data.status = ST_NEG;
      push_data.last   = 1'b1;
    end else if (start && oob) begin
      push_data.status = ST_OOB;
      push_data.last   = 1'b1;
    end else if (start && (rw == '0 || rh == '0)) begin
      push_data.status = ST_OK;
      push_data.last   = 1'b1;
    end else begin
      push_data.status = ST_OK;
      push_data.we     = 1'b1;
      push_data.copy   = copy;
      push_data.pixel  = copy ? in_source_pixel : cfg.fill_colour;
      push_data.col    = col;
      push_data.row    = row;
      push_data.cx     = (copy && cfg.mode[MODE_MIRX]) ? rw - 16'd1 - col : col;
      push_data.cy     = (copy && cfg.mode[MODE_MIRY]) ? rh - 16'd1 - row : row;
      push_data.last   = col_end && row_end;
      if (col_end && row_end) begin
        job_active_nxt = 1'b0;
        col_nxt        = '0;
        row_nxt        = '0;
      end else if (col_end) begin
        job_active_nxt = 1'b1;
        col_nxt        = '0;
        row_nxt        = row + 16'd1;
      end else begin
        job_active_nxt = 1'b1;
        col_nxt        = col + 16'd1;
        row_nxt        = row;
      end
    end
  end

  // job state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
    end else if (push) begin
      job_active_r <= job_active_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

endmodule

// ----- rtl/core/rbag_back.sv -----
`timescale 1ns / 1ps

module rbag_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rbag_pkg::cfg_t   cfg,
  input  rbag_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [33:0]      out_write_offset,
  output logic [33:0]      out_read_offset,
  output logic [31:0]      out_write_pixel,
  output logic             out_write_enable,
  output logic [1:0]       out_status,
  output logic             out_last
);
  import rbag_pkg::*;

  logic        s1_v_r, out_v_r;
  logic        s1_ready, s2_ready;
  entry_t      s1_e_r;
  logic [32:0] pw_r, pr_r, pw, pr;
  logic [16:0] wy, ry;
  logic [31:0] wsum, rsum;
  coord_t      dw, sw, dx, dy, sx, sy;

  assign s2_ready  = !out_v_r || !out_stall;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign pop       = head_valid && s1_ready;
  assign out_valid = out_v_r;

  // row products
  always_comb begin
    dw = fld(cfg.dst_size, 1'b0);
    sw = fld(cfg.src_size, 1'b0);
    dx = fld(cfg.dst_origin, 1'b0); dy = fld(cfg.dst_origin, 1'b1);
    sx = fld(cfg.src_origin, 1'b0); sy = fld(cfg.src_origin, 1'b1);
    wy = {1'b0, dy} + {1'b0, head.cy};
    ry = {1'b0, sy} + {1'b0, head.row};
    pw = 33'(wy) * 33'(dw);
    pr = 33'(ry) * 33'(sw);
  end

  // column add, offsets wrap to 34 bits
  always_comb begin
    wsum = pw_r[31:0] + 32'(dx) + 32'(s1_e_r.cx);
    rsum = pr_r[31:0] + 32'(sx) + 32'(s1_e_r.col);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= head_valid;
      if (s2_ready) out_v_r <= s1_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_e_r <= head;
      pw_r   <= pw;
      pr_r   <= pr;
    end
    if (s2_ready && s1_v_r) begin
      out_write_offset <= s1_e_r.we ? {wsum, 2'b00} : '0;
      out_read_offset  <= (s1_e_r.we && s1_e_r.copy) ? {rsum, 2'b00} : '0;
      out_write_pixel  <= s1_e_r.pixel;
      out_write_enable <= s1_e_r.we;
      out_status       <= s1_e_r.status;
      out_last         <= s1_e_r.last;
    end
  end

endmodule

// ----- rtl/core/rect_blit_address_generator.sv -----
`timescale 1ns / 1ps
// path: an accepted item is written into the queue, then registered in the row
//   multiply stage, then in the column add stage that drives the outputs
// throughput: one item per cycle while neither in_stall nor out_stall is raised, set by the
//   front raster counters and one multiplier per offset in the back; a four-item queue decouples the two
// reset: synchronous active-low clears job state, queue, stage valids and config

module rect_blit_address_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_source_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [33:0] out_write_offset,
  output logic [33:0] out_read_offset,
  output logic [31:0] out_write_pixel,
  output logic        out_write_enable,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rbag_pkg::*;

  cfg_t   cfg_r;
  entry_t push_data, head;
  logic   push, pop, q_full, q_not_empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:     cfg_r.mode        <= cfg_data[2:0];
        CFG_DST_SIZE: cfg_r.dst_size    <= cfg_data;
        CFG_SRC_SIZE: cfg_r.src_size    <= cfg_data;
        CFG_DST_ORG:  cfg_r.dst_origin  <= cfg_data;
        CFG_SRC_ORG:  cfg_r.src_origin  <= cfg_data;
        CFG_RECT:     cfg_r.rect_size   <= cfg_data;
        CFG_FILL:     cfg_r.fill_colour <= cfg_data;
        default: ;
      endcase
    end
  end

  rbag_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_source_pixel (in_source_pixel),
    .q_full          (q_full),
    .push            (push),
    .push_data       (push_data)
  );

  rbag_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  rbag_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (head),
    .head_valid       (q_not_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_offset (out_write_offset),
    .out_read_offset  (out_read_offset),
    .out_write_pixel  (out_write_pixel),
    .out_write_enable (out_write_enable),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  // an error or empty item always ends its job
  a_nowrite_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_last)
    else $error("item without write is not last");

  // a failed check never carries a write
  a_err_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_write_enable)
    else $error("error item carries a write");

  // an item without a write has zero offsets
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_write_offset == '0 && out_read_offset == '0)
    else $error("item without write has offsets");

  // the queue only pushes back when it is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_not_empty)
    else $error("input stalled with empty queue");

endmodule
